>>> sv/preemptive_rm_edf_tick_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RM/EDF tick scheduler
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_RM_EDF_TICK_SCHEDULER_UNIT_MACROS_SVH
`define PREEMPTIVE_RM_EDF_TICK_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset
`define RMEDF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, checked on every clock outside reset
`define RMEDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

>>> sv/rmedf_pkg.sv
// ----------------------------------------------------------------------------
// RM/EDF scheduler package
// Item types, command and event codes, and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package rmedf_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int MAX_JOBS_DEF  = 32;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_DONE    = 2'd1;
    localparam logic [1:0] EV_PREEMPT = 2'd2;

    localparam logic [1:0] KIND_FRESH  = 2'd0;
    localparam logic [1:0] KIND_RESUME = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;
    localparam logic [1:0] KIND_SAME   = 2'd3;

    localparam logic CFG_POLICY     = 1'b0;
    localparam logic CFG_TASK_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  task_index;
        logic [15:0] exec_time;
        logic [15:0] period_len;
    } in_item_t;

    typedef struct packed {
        logic [31:0] tick_time;
        logic [3:0]  prev_task;
        logic [1:0]  prev_event;
        logic [3:0]  next_task;
        logic [1:0]  next_kind;
        logic [31:0] preempt_total;
        logic        release_dropped;
    } out_item_t;

    // Operands of the shared priority compare
    typedef struct packed {
        logic        policy;
        logic [31:0] cand_dl;
        logic [15:0] cand_per;
        logic [31:0] cand_seq;
        logic [31:0] best_dl;
        logic [15:0] best_per;
        logic [31:0] best_seq;
    } cmp_req_t;

    // Zero period or execution time counts as one
    function automatic logic [15:0] eff16(input logic [15:0] x);
        return (x == 16'd0) ? 16'd1 : x;
    endfunction

endpackage
`default_nettype wire

>>> sv/rmedf_cmp.sv
// ----------------------------------------------------------------------------
// RM/EDF priority compare
// True when the candidate job strictly beats the best job so far.
// ----------------------------------------------------------------------------
`default_nettype none
module rmedf_cmp (
    input  rmedf_pkg::cmp_req_t req,
    output logic                beats
);
    import rmedf_pkg::*;

    logic [31:0] key_c;
    logic [31:0] key_b;

    // Pick the key by policy, break ties on release order
    always_comb begin
        key_c = req.policy ? req.cand_dl : {16'd0, req.cand_per};
        key_b = req.policy ? req.best_dl : {16'd0, req.best_per};
        if (key_c != key_b) begin
            beats = key_c < key_b;
        end else begin
            beats = req.cand_seq < req.best_seq;
        end
    end

endmodule
`default_nettype wire

>>> sv/preemptive_rm_edf_tick_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Preemptive RM/EDF tick scheduler
// Releases periodic jobs on each tick, picks the highest-priority job with
// one shared compare unit and reports the resulting transition.
// ----------------------------------------------------------------------------
//  channel | ports                         | payload
//  input   | s_valid s_ready s_data        | in_item_t
//  result  | m_valid m_ready m_data        | out_item_t (one per tick)
//  config  | cfg_valid cfg_ready cfg_index | cfg_data, 0 policy, 1 task_count
//
//  Load and start items are handled in the idle state. A tick first releases
//  jobs for the n tasks in use, then scans every job slot for priority through
//  the shared compare unit, then finishes and writes its result; no new item is
//  accepted until the tick has returned to idle.
//  Reset is synchronous; the task tables are undefined until loaded.
//  A finished result waits in the output register; a further tick stalls
//  in its last step until that register is free. Configuration writes are
//  accepted only while idle with no item offered.
// ----------------------------------------------------------------------------
`default_nettype none
module preemptive_rm_edf_tick_scheduler_unit #(
    parameter int MAX_TASKS = rmedf_pkg::MAX_TASKS_DEF,
    parameter int MAX_JOBS  = rmedf_pkg::MAX_JOBS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rmedf_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rmedf_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [4:0]           cfg_data
);
    import rmedf_pkg::*;

    localparam int TIW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int SW   = $clog2(MAX_JOBS);
    localparam int MAXN = (MAX_TASKS > MAX_JOBS) ? MAX_TASKS : MAX_JOBS;
    localparam int IXW  = $clog2(MAXN + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REL  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]     state_reg;
    logic [IXW-1:0] ix_reg;
    logic [IXW-1:0] n_reg;

    logic        policy_reg;
    logic [4:0]  task_count_reg;

    logic [15:0] exec_tab [MAX_TASKS];
    logic [15:0] per_tab  [MAX_TASKS];
    logic [15:0] cd_reg   [MAX_TASKS];

    logic [MAX_JOBS-1:0] jvalid_reg;
    logic [TIW-1:0]      jtask [MAX_JOBS];
    logic [31:0]         jdl   [MAX_JOBS];
    logic [31:0]         jseq  [MAX_JOBS];
    logic [15:0]         jrem  [MAX_JOBS];

    logic [SW-1:0] run_slot_reg;
    logic          run_valid_reg;
    logic [31:0]   time_reg;
    logic [31:0]   relcnt_reg;
    logic [31:0]   pre_reg;

    logic [TIW-1:0] prev_task_reg;
    logic           prev_pend_reg;
    logic           drop_reg;
    logic           found_reg;
    logic [SW-1:0]  sel_reg;
    logic [31:0]    best_dl_reg;
    logic [15:0]    best_per_reg;
    logic [31:0]    best_seq_reg;

    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic           s_acc;
    logic [SW-1:0]  free_slot;
    logic           free_ok;
    logic [TIW-1:0] ti;
    logic [SW-1:0]  si;
    logic [TIW-1:0] ld_idx;
    logic [IXW-1:0] n_next;
    cmp_req_t       req;
    logic           beats;
    logic           out_free;
    logic [TIW-1:0] sel_task;
    logic [15:0]    sel_exec;
    logic [31:0]    pt_wide;
    logic [31:0]    nt_wide;
    logic           same_job;
    logic           do_preempt;
    logic [31:0]    pre_next;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !s_valid;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign s_acc     = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign ti       = ix_reg[TIW-1:0];
    assign si       = ix_reg[SW-1:0];
    assign ld_idx   = TIW'(s_data.task_index);
    assign n_next   = (32'(task_count_reg) > MAX_TASKS) ? IXW'(MAX_TASKS)
                                                        : IXW'(task_count_reg);
    assign sel_task = jtask[sel_reg];
    assign sel_exec = eff16(exec_tab[sel_task]);
    assign pt_wide  = 32'(prev_task_reg);
    assign nt_wide  = 32'(sel_task);

    // Classify the transition at the end of a tick
    assign same_job   = prev_pend_reg && (sel_reg == run_slot_reg);
    assign do_preempt = found_reg && prev_pend_reg && !same_job;
    assign pre_next   = (do_preempt && pre_reg != 32'hFFFF_FFFF) ? pre_reg + 32'd1 : pre_reg;

    // Find the lowest free job slot
    always_comb begin
        free_slot = '0;
        free_ok   = 1'b0;
        for (int j = MAX_JOBS - 1; j >= 0; j--) begin
            if (!jvalid_reg[j]) begin
                free_slot = SW'(j);
                free_ok   = 1'b1;
            end
        end
    end

    // Feed the shared compare with the scanned slot and the best so far
    always_comb begin
        req.policy   = policy_reg;
        req.cand_dl  = jdl[si];
        req.cand_per = eff16(per_tab[jtask[si]]);
        req.cand_seq = jseq[si];
        req.best_dl  = best_dl_reg;
        req.best_per = best_per_reg;
        req.best_seq = best_seq_reg;
    end

    rmedf_cmp u_cmp (
        .req   (req),
        .beats (beats)
    );

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg     <= 1'b0;
            task_count_reg <= 5'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_POLICY:     policy_reg     <= cfg_data[0];
                CFG_TASK_COUNT: task_count_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Load task table entries
    always_ff @(posedge aclk) begin
        if (s_acc && s_data.command == CMD_LOAD && 32'(s_data.task_index) < MAX_TASKS) begin
            exec_tab[ld_idx] <= s_data.exec_time;
            per_tab[ld_idx]  <= s_data.period_len;
        end
    end

    // Sequencer: release, scan, then finish the tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ix_reg        <= '0;
            n_reg         <= '0;
            jvalid_reg    <= '0;
            run_slot_reg  <= '0;
            run_valid_reg <= 1'b0;
            time_reg      <= '0;
            relcnt_reg    <= '0;
            pre_reg       <= '0;
            m_valid_reg   <= 1'b0;
            found_reg     <= 1'b0;
            for (int k = 0; k < MAX_TASKS; k++) begin
                cd_reg[k] <= '0;
            end
        end else begin
            // Drop the result item once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        case (s_data.command)
                            CMD_TICK: begin
                                prev_task_reg <= run_valid_reg ? jtask[run_slot_reg] : '0;
                                prev_pend_reg <= run_valid_reg && jvalid_reg[run_slot_reg];
                                drop_reg  <= 1'b0;
                                found_reg <= 1'b0;
                                n_reg     <= n_next;
                                ix_reg    <= '0;
                                state_reg <= ST_REL;
                            end
                            CMD_START: begin
                                jvalid_reg    <= '0;
                                run_slot_reg  <= '0;
                                run_valid_reg <= 1'b0;
                                time_reg      <= '0;
                                relcnt_reg    <= '0;
                                pre_reg       <= '0;
                                for (int k = 0; k < MAX_TASKS; k++) begin
                                    cd_reg[k] <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_REL: begin
                    if (ix_reg >= n_reg) begin
                        ix_reg    <= '0;
                        state_reg <= ST_SCAN;
                    end else begin
                        ix_reg <= ix_reg + 1'b1;
                        if (cd_reg[ti] != 16'd0) begin
                            cd_reg[ti] <= cd_reg[ti] - 16'd1;
                        end else begin
                            cd_reg[ti] <= eff16(per_tab[ti]) - 16'd1;
                            if (free_ok) begin
                                jvalid_reg[free_slot] <= 1'b1;
                                jtask[free_slot]      <= ti;
                                jdl[free_slot]        <= time_reg + 32'(eff16(per_tab[ti]));
                                jseq[free_slot]       <= relcnt_reg;
                                jrem[free_slot]       <= eff16(exec_tab[ti]);
                                relcnt_reg            <= relcnt_reg + 32'd1;
                            end else begin
                                drop_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (jvalid_reg[si] && (!found_reg || beats)) begin
                        found_reg    <= 1'b1;
                        sel_reg      <= si;
                        best_dl_reg  <= req.cand_dl;
                        best_per_reg <= req.cand_per;
                        best_seq_reg <= req.cand_seq;
                    end
                    if (32'(ix_reg) == MAX_JOBS - 1) begin
                        state_reg <= ST_DONE;
                    end else begin
                        ix_reg <= ix_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.tick_time       <= time_reg;
                        m_data_reg.prev_task       <= pt_wide[3:0];
                        m_data_reg.release_dropped <= drop_reg;
                        m_data_reg.prev_event      <= do_preempt ? EV_PREEMPT :
                                                      (prev_pend_reg || !run_valid_reg)
                                                      ? EV_NONE : EV_DONE;
                        m_data_reg.next_task       <= found_reg ? nt_wide[3:0] : 4'd0;
                        m_data_reg.next_kind       <= !found_reg ? KIND_IDLE :
                                                      same_job ? KIND_SAME :
                                                      (jrem[sel_reg] == sel_exec)
                                                      ? KIND_FRESH : KIND_RESUME;
                        m_data_reg.preempt_total   <= pre_next;
                        pre_reg                    <= pre_next;
                        time_reg                   <= time_reg + 32'd1;
                        run_valid_reg              <= found_reg;
                        state_reg                  <= ST_IDLE;
                        if (found_reg) begin
                            run_slot_reg <= sel_reg;
                            if (jrem[sel_reg] <= 16'd1) begin
                                jrem[sel_reg]       <= 16'd0;
                                jvalid_reg[sel_reg] <= 1'b0;
                            end else begin
                                jrem[sel_reg] <= jrem[sel_reg] - 16'd1;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/rmedf_checker.sv
// ----------------------------------------------------------------------------
// RM/EDF scheduler port checker
// Watches the top-level ports and flags impossible result items.
// ----------------------------------------------------------------------------
`default_nettype none
`include "preemptive_rm_edf_tick_scheduler_unit_macros.svh"
module rmedf_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire rmedf_pkg::out_item_t m_data,
    input wire logic                 m_valid,
    input wire logic                 m_ready
);
    import rmedf_pkg::*;

    // Hold a stalled result item
    `RMEDF_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // Idle ticks name no task
    `RMEDF_ASSERT_SAME(a_idle, m_valid && m_data.next_kind == KIND_IDLE, m_data.next_task == 4'd0)
    // A preemption never continues the same job and leaves a nonzero preemption total
    `RMEDF_ASSERT_SAME(a_pre, m_valid && m_data.prev_event == EV_PREEMPT, m_data.next_kind != KIND_SAME && m_data.preempt_total != 32'd0)
    // No event code beyond preemption
    `RMEDF_ASSERT_SAME(a_ev, m_valid, m_data.prev_event != 2'd3)

endmodule

bind preemptive_rm_edf_tick_scheduler_unit rmedf_checker u_rmedf_checker (.*);
`default_nettype wire
